@@ hw/rtl/mttt_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI tempo tick timer package
// Shared types, item codes and constants for the tick timer block.
// ----------------------------------------------------------------------------
`default_nettype none

package mttt_pkg;

    // Item kinds.
    typedef enum logic [3:0] {
        KIND_TICK     = 4'd0,
        KIND_WAIT_REL = 4'd1,
        KIND_WAIT_ABS = 4'd2,
        KIND_START    = 4'd3,
        KIND_STOP     = 4'd4,
        KIND_CONTINUE = 4'd5,
        KIND_TEMPO    = 4'd6,
        KIND_SYNC     = 4'd7,
        KIND_ARM      = 4'd8
    } kind_t;

    localparam int unsigned MIN_PERIOD_USECS_DEF = 2000;
    localparam logic [25:0] USECS_PER_MINUTE     = 26'd60000000;
    localparam logic [9:0]  TIMEBASE_RESET       = 10'd100;
    localparam logic [9:0]  TIMEBASE_MAX         = 10'd1000;
    localparam logic [7:0]  TEMPO_RESET          = 8'd60;
    localparam logic [7:0]  TEMPO_MIN            = 8'd8;
    localparam logic [7:0]  TEMPO_MAX            = 8'd250;
    localparam logic [31:0] INTERVAL_RESET       = 32'd10000;
    localparam int unsigned QUEUE_DEPTH          = 2;

    // Input word.
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic        fired;
        logic        armed;
        logic [31:0] current_ticks;
        logic        running;
    } out_word_t;

    // Classified command passed from front to back.
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic [7:0]  tempo;
    } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/mttt_front.sv @@
// ----------------------------------------------------------------------------
// MIDI tempo tick timer front end
// Accepts input words, clamps the tempo and pushes commands into a queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mttt_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire mttt_pkg::in_word_t in_data,
    output logic                   cmd_valid,
    input  wire logic              cmd_pop,
    output mttt_pkg::cmd_t         cmd_data
);
    import mttt_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_reg, rd_reg;
    logic [PW:0]       cnt_reg;
    cmd_t              cmd_in;
    logic              push;
    logic              pop;

    // Clamp the tempo so the back end sees a ready value.
    always_comb
    begin
        cmd_in.kind  = in_data.kind;
        cmd_in.value = in_data.value;
        if (in_data.value[31:8] != 24'd0 || in_data.value[7:0] > TEMPO_MAX)
            cmd_in.tempo = TEMPO_MAX;
        else if (in_data.value[7:0] < TEMPO_MIN)
            cmd_in.tempo = TEMPO_MIN;
        else
            cmd_in.tempo = in_data.value[7:0];
    end

    assign in_stall  = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_data  = mem_reg[rd_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= cmd_in;
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    // The fill level never exceeds the depth.
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(QUEUE_DEPTH)) else $error("queue overflow");
    // A push into a full queue is blocked.
    a_nopush: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !push) else $error("push while full");
    // A lone push raises the count by one.
    a_inc: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count");

endmodule

`default_nettype wire

@@ hw/rtl/mttt_divider.sv @@
// ----------------------------------------------------------------------------
// MIDI tempo tick timer divider
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mttt_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [63:0]      quotient,
    output logic [32:0]      remainder
);
    import mttt_pkg::*;

    logic [63:0] q_reg;
    logic [32:0] r_reg;
    logic [31:0] d_reg;
    logic [6:0]  n_reg;
    logic        busy_reg;
    logic [33:0] trial;

    assign trial     = {r_reg, q_reg[63]} - {2'b0, d_reg};
    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign done      = busy_reg && (n_reg == 7'd0);

    // Shift and subtract.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            n_reg    <= 7'd64;
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg)
            n_reg <= n_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg && n_reg != 7'd0)
        begin
            if (!trial[33])
            begin
                r_reg <= trial[32:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[31:0], q_reg[63]};
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

    // Done only while busy.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg) else $error("done while idle");
    // A start loads the full bit count.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> n_reg == 7'd64) else $error("bad start");
    // Busy counts down by one.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !done && !start |=> n_reg == $past(n_reg) - 1'b1)
        else $error("bad count");

endmodule

`default_nettype wire

@@ hw/rtl/mttt_back.sv @@
// ----------------------------------------------------------------------------
// MIDI tempo tick timer back end
// Executes commands, computes the tick scale and MIDI time, drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module mttt_back #(
    parameter int unsigned MIN_PERIOD_USECS = mttt_pkg::MIN_PERIOD_USECS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [9:0]      cfg_wdata,
    input  wire logic            cmd_valid,
    output logic                 cmd_pop,
    input  wire mttt_pkg::cmd_t  cmd_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output mttt_pkg::out_word_t  out_data
);
    import mttt_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SCALE  = 10'b0000000010,
        ST_SWAIT  = 10'b0000000100,
        ST_MUL    = 10'b0000001000,
        ST_QDIV   = 10'b0000010000,
        ST_QWAIT  = 10'b0000100000,
        ST_APPLY  = 10'b0001000000,
        ST_RSCALE = 10'b0010000000,
        ST_RWAIT  = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [9:0]  timebase_reg;
    logic        run_reg;
    logic [7:0]  tempo_reg;
    logic [31:0] interval_reg, count_reg, offset_reg, now_reg, next_reg, prev_reg;
    logic [31:0] scale_reg;
    logic [63:0] prod_reg;
    logic [31:0] ticks_reg;
    cmd_t        cmd_reg;
    out_word_t   out_reg;
    logic        out_valid_reg;

    logic        div_start;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [63:0] div_q;
    logic [32:0] div_r;
    logic [9:0]  tb_eff;
    logic [17:0] tb_tempo;
    logic [31:0] count_use;
    logic [33:0] round_chk;
    logic [31:0] ticks_rounded;
    logic        needs_ticks;
    logic        needs_rescale;
    logic [31:0] tick_now;
    logic [31:0] wait_t;
    logic        apply_fired;
    logic        apply_armed;

    mttt_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Effective timebase and the scale divisor.
    always_comb
    begin
        if (timebase_reg == 10'd0)
            tb_eff = 10'd1;
        else if (timebase_reg > TIMEBASE_MAX)
            tb_eff = TIMEBASE_MAX;
        else
            tb_eff = timebase_reg;
        tb_tempo = 18'(tempo_reg * tb_eff);
    end

    assign needs_ticks = (cmd_reg.kind == KIND_TICK && run_reg)
                      || (cmd_reg.kind == KIND_TEMPO && cmd_reg.value != 32'd0)
                      || (cmd_reg.kind == KIND_SYNC);
    assign needs_rescale = (cmd_reg.kind == KIND_TEMPO && cmd_reg.value != 32'd0);
    assign count_use = (cmd_reg.kind == KIND_TICK) ? count_reg + 1'b1 : count_reg;
    assign round_chk = {1'b0, div_r} + {3'b0, scale_reg[31:1]};
    assign ticks_rounded = div_q[31:0] + 32'(round_chk >= {2'b0, scale_reg});

    // Tick time, wait target and the result flags of the command in hand.
    assign tick_now    = offset_reg + ticks_reg;
    assign wait_t      = (cmd_reg.kind == KIND_WAIT_REL) ? cmd_reg.value + prev_reg
                                                         : cmd_reg.value;
    assign apply_fired = (cmd_reg.kind == KIND_TICK) && run_reg && (tick_now >= next_reg);
    assign apply_armed = (cmd_reg.kind == KIND_WAIT_REL || cmd_reg.kind == KIND_WAIT_ABS)
                      && wait_t != 32'd0 && wait_t > now_reg;

    // Divider operand selection.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = 32'd1;
        if (state_reg == ST_SCALE || state_reg == ST_RSCALE)
        begin
            div_start    = 1'b1;
            div_dividend = {38'd0, USECS_PER_MINUTE};
            div_divisor  = {14'd0, tb_tempo};
        end
        else if (state_reg == ST_QDIV)
        begin
            div_start    = 1'b1;
            div_dividend = prod_reg;
            div_divisor  = scale_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (cmd_valid && !out_valid_reg) state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_SWAIT;
            ST_SWAIT:  if (div_done) state_next = needs_ticks ? ST_MUL : ST_APPLY;
            ST_MUL:    state_next = ST_QDIV;
            ST_QDIV:   state_next = ST_QWAIT;
            ST_QWAIT:  if (div_done) state_next = ST_APPLY;
            ST_APPLY:  state_next = needs_rescale ? ST_RSCALE : ST_OUT;
            ST_RSCALE: state_next = ST_RWAIT;
            ST_RWAIT:  if (div_done) state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Capture the command and working values.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cmd_reg <= cmd_data;
        if (state_reg == ST_SWAIT && div_done)
            scale_reg <= div_q[31:0];
        if (state_reg == ST_MUL)
            prod_reg <= 64'(count_use) * 64'(interval_reg);
        if (state_reg == ST_QWAIT && div_done)
            ticks_reg <= ticks_rounded;
    end

    // Architectural state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            timebase_reg  <= TIMEBASE_RESET;
            run_reg       <= 1'b0;
            tempo_reg     <= TEMPO_RESET;
            interval_reg  <= INTERVAL_RESET;
            count_reg     <= '0;
            offset_reg    <= '0;
            now_reg       <= '0;
            next_reg      <= '1;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                timebase_reg <= cfg_wdata;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_APPLY)
            begin
                out_reg.fired <= apply_fired;
                out_reg.armed <= apply_armed;
                case (cmd_reg.kind)
                    KIND_TICK:
                    begin
                        if (run_reg)
                        begin
                            count_reg <= count_use;
                            now_reg   <= tick_now;
                            if (apply_fired)
                                next_reg <= '1;
                        end
                    end
                    KIND_WAIT_REL, KIND_WAIT_ABS:
                    begin
                        if (apply_armed)
                        begin
                            next_reg <= wait_t;
                            prev_reg <= wait_t;
                        end
                    end
                    KIND_START:
                    begin
                        offset_reg   <= '0;
                        count_reg    <= '0;
                        next_reg     <= '1;
                        prev_reg     <= '0;
                        now_reg      <= '0;
                        run_reg      <= 1'b1;
                        interval_reg <= (scale_reg < 32'(MIN_PERIOD_USECS))
                                        ? 32'(MIN_PERIOD_USECS) : scale_reg;
                    end
                    KIND_STOP:
                        run_reg <= 1'b0;
                    KIND_CONTINUE:
                    begin
                        run_reg      <= 1'b1;
                        interval_reg <= (scale_reg < 32'(MIN_PERIOD_USECS))
                                        ? 32'(MIN_PERIOD_USECS) : scale_reg;
                    end
                    KIND_TEMPO:
                    begin
                        if (cmd_reg.value != 32'd0)
                        begin
                            offset_reg <= tick_now;
                            count_reg  <= '0;
                            tempo_reg  <= cmd_reg.tempo;
                        end
                    end
                    KIND_SYNC:
                    begin
                        offset_reg   <= tick_now;
                        count_reg    <= '0;
                        interval_reg <= cmd_reg.value;
                    end
                    KIND_ARM:
                    begin
                        if (cmd_reg.value[31])
                        begin
                            next_reg <= now_reg + 1'b1;
                            prev_reg <= now_reg + 1'b1;
                        end
                        else if (cmd_reg.value > now_reg)
                        begin
                            next_reg <= cmd_reg.value;
                            prev_reg <= cmd_reg.value;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            // After a tempo change the timer period comes from the new tempo.
            if (state_reg == ST_RWAIT && div_done)
                interval_reg <= (div_q[31:0] < 32'(MIN_PERIOD_USECS))
                                ? 32'(MIN_PERIOD_USECS) : div_q[31:0];
            if (state_reg == ST_OUT)
            begin
                out_valid_reg         <= 1'b1;
                out_reg.current_ticks <= now_reg;
                out_reg.running       <= run_reg;
            end
        end
    end

    // A result is only raised from the output state.
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT) else $error("stray out");
    // No command is taken while a result waits.
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !out_valid_reg) else $error("pop while busy");
    // The tempo stays in range.
    a_tempo: assert property (@(posedge clk) disable iff (!rst_n)
        tempo_reg >= TEMPO_MIN && tempo_reg <= TEMPO_MAX) else $error("tempo");

endmodule

`default_nettype wire

@@ hw/rtl/midi_tempo_tick_timer_unit.sv @@
// ----------------------------------------------------------------------------
// MIDI tempo tick timer unit
// Turns timer interrupt words and sequencer commands into MIDI tick time.
// ----------------------------------------------------------------------------
// Usage: input words (kind, value) enter on in_valid/in_stall and each gives
// exactly one result word on out_valid/out_stall. A two-entry queue sits
// between the front end and the back end, so up to two words are taken in
// while the back end is busy or a result waits. The timebase register must be
// written with cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
// Division work per word: running ticks and interval resyncs run the scale
// division and the rounded tick division on one shared 64-bit restoring
// divider (one bit per cycle); a nonzero tempo change adds a third division
// for the new timer period; other kinds run the scale division only.
// The back end takes the next word the cycle after a result is accepted and
// handles one word at a time, while the queue takes in further words.
// Reset clears all timer state to its defaults and the timebase to 100.
// A stalled result holds; the back end waits and the queue then fills and
// raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_tempo_tick_timer_unit #(
    parameter int unsigned MIN_PERIOD_USECS = mttt_pkg::MIN_PERIOD_USECS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [9:0]          cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire mttt_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output mttt_pkg::out_word_t      out_data
);
    import mttt_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd_data;

    mttt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_data  (cmd_data)
    );

    mttt_back #(
        .MIN_PERIOD_USECS (MIN_PERIOD_USECS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_data  (cmd_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
